@@ rtl/nfaec_pkg.sv @@
`timescale 1ns / 1ps

package nfaec_pkg;

  localparam int DEF_NUM_STATES = 16;
  localparam int DEF_NUM_EDGES  = 64;

  localparam logic [7:0] EPSILON_RESET = 8'd101;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_STATE  = 2'd0;
  localparam logic [1:0] CFG_EPSILON_CODE = 2'd1;
  localparam logic [1:0] CFG_EDGES_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] edge_slot;
    logic [3:0] edge_source;
    logic [3:0] edge_target;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [15:0] active_states;
    logic        any_active;
  } out_item_t;

  // One edge table entry as stored in the RAM.
  typedef struct packed {
    logic [3:0] src;
    logic [3:0] dst;
    logic [7:0] lab;
  } edge_t;

  typedef struct packed {
    logic load_edge;
    logic init_start;
    logic init_step;
    logic issue;
    logic new_pass;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic table_empty;
    logic more_pass;
  } status_t;

endpackage

@@ rtl/nfaec_in_if.sv @@
`timescale 1ns / 1ps

interface nfaec_in_if import nfaec_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/nfaec_out_if.sv @@
`timescale 1ns / 1ps

interface nfaec_out_if import nfaec_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/nfa_epsilon_closure_step_core.sv @@
`timescale 1ns / 1ps

// Channel   Role    Payload                                           Transfer
// in_ch     sink    operation, edge_slot, edge_source, edge_target,   valid & ready
//                   symbol
// out_ch    source  active_states, any_active                         valid & ready
// cfg       write   cfg_we, cfg_index, cfg_data                       cfg_we high
//
// A load writes its table entry; its result is the unchanged active set. A
// start or step makes P passes over the first L table entries, where L is the
// saturated edge count; if L is nonzero, P is one gather pass for a step, then
// epsilon passes until one adds nothing, at most NUM_STATES + 1 of them.
// The single read port of the edge table RAM sets the pace: one edge per cycle.
// Reset is synchronous; the edge table is not cleared and needs no warm-up.
// A new item is taken while the previous result still waits in the output
// register; the block stalls only to place a finished result there.

module nfa_epsilon_closure_step_core import nfaec_pkg::*; #(
  parameter int NUM_STATES = DEF_NUM_STATES,
  parameter int NUM_EDGES  = DEF_NUM_EDGES
) (
  input  logic          clk,
  input  logic          rst,
  nfaec_in_if.sink      in_ch,
  nfaec_out_if.source   out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  // The controller sequences the table passes; the datapath holds the edge
  // table, the configuration, the active set and the working set that grows
  // over each pass until the epsilon closure reaches its fixed point.
  cmd_t    cmd;
  status_t status;

  nfaec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_op     (op_t'(in_ch.data.operation)),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  nfaec_dp #(
    .NUM_STATES(NUM_STATES),
    .NUM_EDGES (NUM_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_ch.data)
  );

endmodule

@@ rtl/nfaec_ram.sv @@
`timescale 1ns / 1ps

module nfaec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/nfaec_dp.sv @@
`timescale 1ns / 1ps

module nfaec_dp import nfaec_pkg::*; #(
  parameter int NUM_STATES = DEF_NUM_STATES,
  parameter int NUM_EDGES  = DEF_NUM_EDGES
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output status_t   status,
  output out_item_t out_data
);

  localparam int AW = $clog2(NUM_EDGES);
  localparam int LW = $clog2(NUM_EDGES + 1);
  localparam int CW = (LW > 7) ? LW : 7;

  // Configuration registers.
  logic [3:0] start_state;
  logic [7:0] epsilon_code;
  logic [6:0] edges_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state  <= '0;
      epsilon_code <= EPSILON_RESET;
      edges_in_use <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_STATE:  start_state  <= cfg_data[3:0];
        CFG_EPSILON_CODE: epsilon_code <= cfg_data;
        CFG_EDGES_IN_USE: edges_in_use <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  function automatic logic [NUM_STATES-1:0] sbit(input logic [3:0] s);
    // A state at or beyond NUM_STATES shifts out and has no bit.
    return NUM_STATES'(1) << s;
  endfunction

  // Edge table.
  logic [AW-1:0] idx;
  logic          rd_vld;
  edge_t         entry;
  edge_t         wr_entry;
  logic          wr_en;

  assign wr_entry = '{src: in_data.edge_source, dst: in_data.edge_target,
                      lab: in_data.symbol};
  assign wr_en    = cmd.load_edge && (32'(in_data.edge_slot) < NUM_EDGES);

  nfaec_ram #(
    .WIDTH($bits(edge_t)),
    .DEPTH(NUM_EDGES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_data.edge_slot)),
    .wdata (wr_entry),
    .raddr (idx),
    .rdata (entry)
  );

  // Scan limit, saturated at the table depth.
  logic [CW-1:0] eiu_w;
  logic [CW-1:0] lim;

  assign eiu_w = CW'(edges_in_use);
  assign lim   = (eiu_w > CW'(NUM_EDGES)) ? CW'(NUM_EDGES) : eiu_w;

  // Set registers.
  logic [NUM_STATES-1:0] active;
  logic [NUM_STATES-1:0] acc;
  logic [NUM_STATES-1:0] from_set;
  logic [NUM_STATES-1:0] add;
  logic [7:0]            match;
  logic                  gather;
  logic                  changed;
  logic                  hit;
  logic                  grow;

  assign from_set = gather ? active : acc;
  assign hit      = rd_vld && (entry.lab == match) && (|(from_set & sbit(entry.src)));
  assign add      = hit ? sbit(entry.dst) : '0;
  assign grow     = |(add & ~acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      idx     <= '0;
      gather  <= 1'b0;
      changed <= 1'b0;
      active  <= '0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.init_start || cmd.init_step || cmd.new_pass) begin
        idx <= '0;
      end else if (cmd.issue) begin
        idx <= idx + AW'(1);
      end
      if (cmd.init_start || cmd.new_pass) begin
        gather <= 1'b0;
      end else if (cmd.init_step) begin
        gather <= 1'b1;
      end
      if (cmd.init_start || cmd.init_step || cmd.new_pass) begin
        changed <= 1'b0;
      end else if (grow) begin
        changed <= 1'b1;
      end
      if (cmd.commit) begin
        active <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_start) begin
      acc   <= sbit(start_state);
      match <= epsilon_code;
    end else if (cmd.init_step) begin
      acc   <= '0;
      match <= in_data.symbol;
    end else begin
      acc <= acc | add;
      if (cmd.new_pass) begin
        match <= epsilon_code;
      end
    end
  end

  assign status.last        = (CW'(idx) == (lim - CW'(1)));
  assign status.table_empty = (lim == '0);
  assign status.more_pass   = gather || changed || grow;

  // Result register.
  logic [15:0] view;

  if (NUM_STATES >= 16) begin : g_wide
    assign view = active[15:0];
  end else begin : g_narrow
    assign view = {{(16 - NUM_STATES){1'b0}}, active};
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.active_states <= view;
      out_data.any_active    <= |active;
    end
  end

endmodule

@@ rtl/nfaec_ctrl.sv @@
`timescale 1ns / 1ps

module nfaec_ctrl import nfaec_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  op_t     in_op,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   in_take;
  logic   out_free;

  // The input is open only while idle and out of reset.
  assign in_ready = (state == ST_IDLE) && !rst;
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_op)
            OP_LOAD: begin
              cmd.load_edge = 1'b1;
              state_next    = ST_FINISH;
            end
            OP_START: begin
              cmd.init_start = 1'b1;
              state_next     = status.table_empty ? ST_COMMIT : ST_SCAN;
            end
            OP_STEP: begin
              cmd.init_step = 1'b1;
              state_next    = status.table_empty ? ST_COMMIT : ST_SCAN;
            end
            OP_NONE: begin
              state_next = ST_FINISH;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.more_pass) begin
          cmd.new_pass = 1'b1;
          state_next   = ST_SCAN;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/nfaec_chk.sv @@
`timescale 1ns / 1ps

module nfaec_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] active_states,
  input logic        any_active
);

  // One item is worked at a time: the input closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item was in progress");

  // A new result appears only after the input was closed for work.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item being worked");

  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (any_active == (active_states != 16'd0)))
    else $error("any_active disagrees with active_states");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(active_states)))
    else $error("stalled result changed or vanished");

endmodule

bind nfa_epsilon_closure_step_core nfaec_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .active_states (out_ch.data.active_states),
  .any_active    (out_ch.data.any_active)
);

@@ test/tb_nfa_epsilon_closure_step_core.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the NFA active-set engine. It keeps its own copy of the
// edge table, the active bitmap and the three registers, and predicts the bitmap
// that each transfer on the input channel must produce.
module tb_nfa_epsilon_closure_step_core;
  import nfaec_pkg::*;

  localparam int N_STATES        = DEF_NUM_STATES;
  localparam int N_EDGES         = DEF_NUM_EDGES;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 225;
  // The longest correct silence is one step over a full table (17 passes)
  // plus a long receiver stall, so this leaves a wide margin.
  localparam int STALL_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 40;

  // One row of the directed part. A row either writes a register or sends an
  // item; where the expected bitmap is obvious it is typed in the row itself.
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_index;
    logic [7:0]  reg_value;
    op_t         op;
    logic [5:0]  slot;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [7:0]  sym;
    logic        typed;
    logic [15:0] want_set;
  } stim_row_t;

  localparam int N_ROWS = 27;

  // The first rows run right after reset with no edges in use. Then a small
  // graph is loaded: 0 -e-> 1 -a-> 2 -e-> 3 -e-> 15, 15 -0-> 0, a self loop on
  // state 2, and one entry at the top slot that is not scanned at first.
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{1'b0, CFG_START_STATE,  8'd0,   OP_NONE,  6'd63, 4'd15, 4'd15, 8'd255, 1'b1, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_START, 6'd0,  4'd0,  4'd0,  8'd0,   1'b1, 16'h0001},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_STEP,  6'd0,  4'd0,  4'd0,  8'd0,   1'b1, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_STEP,  6'd63, 4'd15, 4'd15, 8'd255, 1'b1, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_START, 6'd0,  4'd0,  4'd0,  8'd0,   1'b1, 16'h0001},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_LOAD,  6'd0,  4'd0,  4'd1,  8'd101, 1'b1, 16'h0001},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_LOAD,  6'd1,  4'd1,  4'd2,  8'd97,  1'b1, 16'h0001},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_LOAD,  6'd2,  4'd2,  4'd3,  8'd101, 1'b1, 16'h0001},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_LOAD,  6'd3,  4'd3,  4'd15, 8'd101, 1'b1, 16'h0001},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_LOAD,  6'd4,  4'd15, 4'd0,  8'd0,   1'b1, 16'h0001},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_LOAD,  6'd5,  4'd2,  4'd2,  8'd97,  1'b1, 16'h0001},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_LOAD,  6'd63, 4'd15, 4'd15, 8'd255, 1'b1, 16'h0001},
    '{1'b1, CFG_EDGES_IN_USE, 8'd6,   OP_NONE,  6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_START, 6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_STEP,  6'd0,  4'd0,  4'd0,  8'd97,  1'b0, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_STEP,  6'd0,  4'd0,  4'd0,  8'd101, 1'b0, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_STEP,  6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_STEP,  6'd0,  4'd0,  4'd0,  8'd200, 1'b0, 16'h0000},
    '{1'b1, CFG_EPSILON_CODE, 8'd0,   OP_NONE,  6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000},
    '{1'b1, CFG_START_STATE,  8'd15,  OP_NONE,  6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_START, 6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_STEP,  6'd0,  4'd0,  4'd0,  8'd97,  1'b0, 16'h0000},
    '{1'b1, CFG_EPSILON_CODE, 8'd255, OP_NONE,  6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000},
    '{1'b1, CFG_EDGES_IN_USE, 8'd0,   OP_NONE,  6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_START, 6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000},
    '{1'b0, CFG_START_STATE,  8'd0,   OP_NONE,  6'd0,  4'd0,  4'd0,  8'd0,   1'b1, 16'h8000},
    '{1'b1, CFG_START_STATE,  8'd0,   OP_NONE,  6'd0,  4'd0,  4'd0,  8'd0,   1'b0, 16'h0000}
  };

  // Register settings of the random phases; a negative entry is drawn at random.
  // The extremes of all three registers appear among them, including an edge
  // count past the table size, which the block must saturate.
  localparam int PHASE_START [N_PHASES] = '{0, 15, 7, -1, -1, 15, -1, 0};
  localparam int PHASE_EPS   [N_PHASES] = '{101, 0, 255, -1, -1, 0, -1, 255};
  localparam int PHASE_EDGES [N_PHASES] = '{64, 127, 16, 65, 8, 0, 40, 100};

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  nfaec_in_if  in_ch ();
  nfaec_out_if out_ch ();

  nfa_epsilon_closure_step_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted copy of the block: the edge table, which entries hold a written
  // edge, the active bitmap and the three registers.
  logic [3:0]  edge_from  [N_EDGES];
  logic [3:0]  edge_to    [N_EDGES];
  logic [7:0]  edge_label [N_EDGES];
  bit          edge_written [N_EDGES];
  logic [15:0] nfa_active;
  logic [3:0]  start_reg;
  logic [7:0]  eps_reg;
  logic [6:0]  edges_reg;

  // Bitmaps still owed by the block, oldest first.
  out_item_t   expected_sets [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  // A few labels besides the epsilon code, so that random edges and steps meet.
  logic [7:0]  alphabet [3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of table entries that one pass scans; the register saturates at the
  // table size.
  function automatic int scan_count();
    return (int'(edges_reg) > N_EDGES) ? N_EDGES : int'(edges_reg);
  endfunction

  // Targets of every scanned edge that carries the label and leaves a state in
  // the given set.
  function automatic logic [15:0] follow_label(input logic [15:0] from_set,
                                               input logic [7:0] label);
    logic [15:0] reached;
    reached = '0;
    for (int i = 0; i < scan_count(); i++) begin
      if (edge_label[i] == label && from_set[edge_from[i]]) reached[edge_to[i]] = 1'b1;
    end
    return reached;
  endfunction

  // Growing the set along epsilon edges is monotone, so after one pass per
  // state plus one the set has reached its fixed point; extra passes are no-ops.
  function automatic logic [15:0] eps_closure(input logic [15:0] seed);
    logic [15:0] grown;
    grown = seed;
    for (int pass = 0; pass <= N_STATES; pass++) grown = grown | follow_label(grown, eps_reg);
    return grown;
  endfunction

  // Applies one accepted item to the predicted state and returns its result.
  function automatic out_item_t advance_nfa(input in_item_t it);
    out_item_t res;
    case (op_t'(it.operation))
      OP_LOAD: begin
        edge_from[it.edge_slot]    = it.edge_source;
        edge_to[it.edge_slot]      = it.edge_target;
        edge_label[it.edge_slot]   = it.symbol;
        edge_written[it.edge_slot] = 1'b1;
      end
      OP_START: nfa_active = eps_closure(16'd1 << start_reg);
      OP_STEP:  nfa_active = eps_closure(follow_label(nfa_active, it.symbol));
      default: ;
    endcase
    res.active_states = nfa_active;
    res.any_active    = |nfa_active;
    return res;
  endfunction

  function automatic logic [7:0] pick_label();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return eps_reg;
    if (roll < 85) return alphabet[$urandom_range(2)];
    return 8'($urandom_range(255));
  endfunction

  // Random item. Loads mostly land inside the scanned part of the table so that
  // they shape later steps. A start or step that would scan an entry never
  // written is turned into a load of the lowest such entry instead.
  function automatic in_item_t make_random_item();
    in_item_t it;
    int       roll;
    int       hole;
    it.edge_slot   = 6'($urandom_range(63));
    it.edge_source = 4'($urandom_range(15));
    it.edge_target = 4'($urandom_range(15));
    it.symbol      = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 35) begin
      it.operation = OP_LOAD;
      if (scan_count() > 0 && $urandom_range(9) < 8)
        it.edge_slot = 6'($urandom_range(scan_count() - 1));
      it.symbol = pick_label();
    end else if (roll < 50) begin
      it.operation = OP_START;
    end else if (roll < 95) begin
      it.operation = OP_STEP;
      it.symbol    = pick_label();
    end else begin
      it.operation = OP_NONE;
    end
    if (it.operation == OP_START || it.operation == OP_STEP) begin
      hole = -1;
      for (int i = scan_count() - 1; i >= 0; i--) begin
        if (!edge_written[i]) hole = i;
      end
      if (hole >= 0) begin
        it.operation = OP_LOAD;
        it.edge_slot = 6'(hole);
        it.symbol    = pick_label();
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one item after a random gap and holds it until the transfer. The
  // expectation is queued at the transfer edge, ahead of the matching result.
  task automatic push_item(input in_item_t it, input bit typed, input logic [15:0] want_set);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = advance_nfa(it);
    if (typed) begin
      predicted.active_states = want_set;
      predicted.any_active    = |want_set;
    end
    expected_sets.push_back(predicted);
  endtask

  // Registers only change while the block is idle, once every item has
  // produced its result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_sets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_START_STATE:  start_reg = val[3:0];
      CFG_EPSILON_CODE: eps_reg   = val;
      CFG_EDGES_IN_USE: edges_reg = val[6:0];
      default: ;
    endcase
  endtask

  // The receiver drops ready at random at the rate of the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_sets.size() == 0) begin
        report_mismatch("result with none pending", got.active_states, 16'h0000);
      end else begin
        want = expected_sets.pop_front();
        if (got.active_states !== want.active_states)
          report_mismatch("active_states", got.active_states, want.active_states);
        if (got.any_active !== want.any_active)
          report_mismatch("any_active", 16'(got.any_active), 16'(want.any_active));
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either channel means a hang.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("nfa_epsilon_closure_step_core regression: fail");
      $finish;
    end
  end

  initial begin
    in_item_t  it;
    stim_row_t row;
    int        start_val;
    int        eps_val;
    int        edges_val;

    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_START_STATE;
    cfg_data     = 8'd0;
    rst          = 1'b1;

    // The predicted state after reset: the table is unwritten, no state is
    // active and the registers hold their reset values.
    for (int i = 0; i < N_EDGES; i++) begin
      edge_from[i]    = '0;
      edge_to[i]      = '0;
      edge_label[i]   = '0;
      edge_written[i] = 1'b0;
    end
    nfa_active = '0;
    start_reg  = '0;
    eps_reg    = EPSILON_RESET;
    edges_reg  = '0;
    alphabet   = '{8'd97, 8'd98, 8'd0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset behavior, the unused operation code, a step on the
    // epsilon code, a step that matches nothing, a start state with outgoing
    // epsilon edges, and an empty edge table.
    for (int r = 0; r < N_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.is_cfg) begin
        settle();
        write_reg(row.reg_index, row.reg_value);
      end else begin
        it.operation   = row.op;
        it.edge_slot   = row.slot;
        it.edge_source = row.src;
        it.edge_target = row.dst;
        it.symbol      = row.sym;
        push_item(it, row.typed, row.want_set);
      end
    end

    // Random phases. Each one rewrites all three registers and cycles through
    // the idling patterns: none, a slow sender, a slow receiver, and both.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      start_val = (PHASE_START[ph] < 0) ? $urandom_range(15) : PHASE_START[ph];
      eps_val   = (PHASE_EPS[ph] < 0) ? $urandom_range(255) : PHASE_EPS[ph];
      edges_val = PHASE_EDGES[ph];
      write_reg(CFG_START_STATE, 8'(start_val));
      write_reg(CFG_EPSILON_CODE, 8'(eps_val));
      write_reg(CFG_EDGES_IN_USE, 8'(edges_val));
      alphabet = '{eps_reg + 8'd1, eps_reg + 8'd2, eps_reg + 8'd7};
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it = make_random_item();
        push_item(it, 1'b0, 16'h0000);
      end
    end

    // Wait for the last results, then a little longer so that any stray
    // result would still be caught by the checker.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("nfa_epsilon_closure_step_core regression: pass");
    end else begin
      $display("nfa_epsilon_closure_step_core regression: fail");
    end
    $finish;
  end

endmodule
